/* rtl/diff_drive_wheel_pid_top_assert.svh */
// Assertion macros used by the top-level file to check this block.
`ifndef DIFF_DRIVE_WHEEL_PID_TOP_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_PID_TOP_ASSERT_SVH

// Checked on every rising edge while reset is low.
`define DDWP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising edge, reset included.
`define DDWP_ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/ddwp_pkg.sv */
package ddwp_pkg;

   localparam int AccumBitsDefault = 32;
   localparam int CsrIndexBits     = 4;

   localparam logic [CsrIndexBits-1:0] REG_GAIN_P_LEFT  = 4'd0;
   localparam logic [CsrIndexBits-1:0] REG_GAIN_I_LEFT  = 4'd1;
   localparam logic [CsrIndexBits-1:0] REG_GAIN_D_LEFT  = 4'd2;
   localparam logic [CsrIndexBits-1:0] REG_GAIN_P_RIGHT = 4'd3;
   localparam logic [CsrIndexBits-1:0] REG_GAIN_I_RIGHT = 4'd4;
   localparam logic [CsrIndexBits-1:0] REG_GAIN_D_RIGHT = 4'd5;
   localparam logic [CsrIndexBits-1:0] REG_HALF_TRACK   = 4'd6;
   localparam logic [CsrIndexBits-1:0] REG_SLEW_PER_MS  = 4'd7;

   localparam logic [15:0] GAIN_P_RESET     = 16'd3840;
   localparam logic [15:0] GAIN_I_RESET     = 16'd896;
   localparam logic [15:0] GAIN_D_RESET     = 16'd16384;
   localparam logic [15:0] HALF_TRACK_RESET = 16'd9306;
   localparam logic [14:0] SLEW_RESET       = 15'd1229;

   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_MEASURE = 1'b1;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] cmd_linear;
      logic signed [15:0] cmd_angular;
      logic [15:0]        elapsed_ms;
      logic signed [15:0] meas_left;
      logic signed [15:0] meas_right;
   } ddwp_req_type;

   typedef struct packed {
      logic [15:0]        duty_left;
      logic [15:0]        duty_right;
      logic               dir_left;
      logic               dir_right;
      logic signed [15:0] target_left;
      logic signed [15:0] target_right;
   } ddwp_rsp_type;

   // Transaction after the shared multipliers of the front stage.
   typedef struct packed {
      logic               kind;
      logic signed [15:0] cmd_linear;
      logic signed [16:0] wheel_term;
      logic [30:0]        max_step;
      logic signed [15:0] meas_left;
      logic signed [15:0] meas_right;
   } ddwp_front_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } ddwp_adv_type;

   typedef struct packed {
      logic [15:0] kp;
      logic [15:0] ki;
      logic [15:0] kd;
   } ddwp_gain_type;

   typedef struct packed {
      logic [15:0]        duty;
      logic signed [15:0] setpoint;
   } ddwp_lane_out_type;

endpackage

/* rtl/ddwp_front.sv */
module ddwp_front
   import ddwp_pkg::*;
(
   input  logic           clock,
   input  logic           load,
   input  ddwp_req_type   req,
   input  logic [15:0]    half_track,
   input  logic [14:0]    slew_per_ms,
   output ddwp_front_type stage_out
);

   logic signed [32:0] term_product;
   logic [30:0]        step_product;
   ddwp_front_type     stage_ff;
   ddwp_front_type     stage_in;

   always_comb begin
      term_product = req.cmd_angular * $signed({1'b0, half_track});
      step_product = slew_per_ms * req.elapsed_ms;

      stage_in.kind       = req.kind;
      stage_in.cmd_linear = req.cmd_linear;
      // The arithmetic shift by 16 rounds toward minus infinity.
      stage_in.wheel_term = term_product[32:16];
      stage_in.max_step   = step_product;
      stage_in.meas_left  = req.meas_left;
      stage_in.meas_right = req.meas_right;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* rtl/ddwp_lane.sv */
module ddwp_lane
   import ddwp_pkg::*;
#(
   parameter int ACCUM_BITS = AccumBitsDefault
)
(
   input  logic               clock,
   input  logic               reset,
   input  ddwp_adv_type       adv,
   input  ddwp_front_type     front,
   input  logic signed [15:0] meas,
   input  logic               subtract_term,
   input  ddwp_gain_type      gain,
   output ddwp_lane_out_type  lane_out
);

   localparam int AccLoBits = ACCUM_BITS / 2;
   localparam int AccHiBits = ACCUM_BITS - AccLoBits;
   localparam int HiBits    = AccHiBits + 17;
   localparam int LoBits    = AccLoBits + 16;
   localparam int SumBits   = ACCUM_BITS + 19;

   // Wheel state.
   logic signed [15:0]           setpoint_ff, setpoint_in;
   logic signed [ACCUM_BITS-1:0] accum_ff, accum_in;
   logic signed [16:0]           last_err_ff, last_err_in;
   logic [15:0]                  duty_hold_ff, duty_hold_in;

   // Stage 1: state update.
   logic [17:0]        lin_ext, term_ext, cmd_sum;
   logic [15:0]        target;
   logic [16:0]        diff, diff_mag;
   logic [15:0]        step;
   logic [16:0]        sp_ext, sp_abs, meas_ext, meas_abs;
   logic [16:0]        err;
   logic [ACCUM_BITS:0] acc_wide;
   logic [ACCUM_BITS-1:0] acc_sat;
   logic [17:0]        deriv;

   logic                         s1_kind_ff;
   logic signed [15:0]           s1_sp_ff, s1_sp_in;
   logic signed [16:0]           s1_err_ff;
   logic signed [ACCUM_BITS-1:0] s1_acc_ff;
   logic signed [17:0]           s1_deriv_ff;

   // Stage 2: products.
   logic signed [33:0]        prod_p_in;
   logic signed [34:0]        prod_d_in;
   logic [LoBits-1:0]         prod_lo_in;
   logic signed [HiBits-1:0]  prod_hi_in;
   logic                      s2_kind_ff;
   logic signed [15:0]        s2_sp_ff;
   logic signed [33:0]        s2_prod_p_ff;
   logic signed [34:0]        s2_prod_d_ff;
   logic [LoBits-1:0]         s2_prod_lo_ff;
   logic signed [HiBits-1:0]  s2_prod_hi_ff;

   // Stage 3: sum and clamp.
   logic [SumBits-1:0] sum;
   logic [15:0]        duty;
   ddwp_lane_out_type  s3_ff, s3_in;

   always_comb begin
      lin_ext  = {{2{front.cmd_linear[15]}}, front.cmd_linear};
      term_ext = {front.wheel_term[16], front.wheel_term};
      cmd_sum  = subtract_term ? (lin_ext - term_ext) : (lin_ext + term_ext);
      if ((cmd_sum[17:15] == 3'b000) || (cmd_sum[17:15] == 3'b111)) begin
         target = cmd_sum[15:0];
      end else begin
         target = cmd_sum[17] ? 16'h8000 : 16'h7fff;
      end

      // The step never passes the target, so the new setpoint stays in range.
      diff     = {target[15], target} - {setpoint_ff[15], setpoint_ff};
      diff_mag = diff[16] ? (17'd0 - diff) : diff;
      step     = (front.max_step < {14'd0, diff_mag}) ? front.max_step[15:0]
                                                      : diff_mag[15:0];

      sp_ext   = {setpoint_ff[15], setpoint_ff};
      sp_abs   = sp_ext[16] ? (17'd0 - sp_ext) : sp_ext;
      meas_ext = {meas[15], meas};
      meas_abs = meas_ext[16] ? (17'd0 - meas_ext) : meas_ext;
      err      = sp_abs - meas_abs;

      acc_wide = {accum_ff[ACCUM_BITS-1], accum_ff}
               + {{(ACCUM_BITS-16){err[16]}}, err};
      if (acc_wide[ACCUM_BITS] != acc_wide[ACCUM_BITS-1]) begin
         acc_sat = acc_wide[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                        : {1'b0, {(ACCUM_BITS-1){1'b1}}};
      end else begin
         acc_sat = acc_wide[ACCUM_BITS-1:0];
      end
      deriv = {err[16], err} - {last_err_ff[16], last_err_ff};

      setpoint_in = setpoint_ff;
      accum_in    = accum_ff;
      last_err_in = last_err_ff;
      if (adv.s1) begin
         if (front.kind == KIND_MEASURE) begin
            accum_in    = acc_sat;
            last_err_in = err;
         end else begin
            setpoint_in = diff[16] ? (setpoint_ff - step) : (setpoint_ff + step);
         end
      end
      s1_sp_in = (front.kind == KIND_MEASURE) ? setpoint_ff
                 : (diff[16] ? (setpoint_ff - step) : (setpoint_ff + step));
   end

   always_comb begin
      prod_p_in  = $signed({1'b0, gain.kp}) * s1_err_ff;
      prod_d_in  = $signed({1'b0, gain.kd}) * s1_deriv_ff;
      prod_lo_in = gain.ki * s1_acc_ff[AccLoBits-1:0];
      prod_hi_in = $signed({1'b0, gain.ki}) * $signed(s1_acc_ff[ACCUM_BITS-1:AccLoBits]);
   end

   always_comb begin
      sum = {{(SumBits-34){s2_prod_p_ff[33]}}, s2_prod_p_ff}
          + {{(SumBits-35){s2_prod_d_ff[34]}}, s2_prod_d_ff}
          + {{(SumBits-HiBits-AccLoBits){s2_prod_hi_ff[HiBits-1]}}, s2_prod_hi_ff,
             {AccLoBits{1'b0}}}
          + {{(SumBits-LoBits){1'b0}}, s2_prod_lo_ff};
      if (sum[SumBits-1]) begin
         duty = 16'd0;
      end else if (|sum[SumBits-1:28]) begin
         duty = 16'hffff;
      end else begin
         duty = sum[27:12];
      end

      duty_hold_in = duty_hold_ff;
      if (adv.s3 && (s2_kind_ff == KIND_MEASURE)) begin
         duty_hold_in = duty;
      end
      s3_in.duty     = (s2_kind_ff == KIND_MEASURE) ? duty : duty_hold_ff;
      s3_in.setpoint = s2_sp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= '0;
         accum_ff     <= '0;
         last_err_ff  <= '0;
         duty_hold_ff <= '0;
      end else begin
         setpoint_ff  <= setpoint_in;
         accum_ff     <= accum_in;
         last_err_ff  <= last_err_in;
         duty_hold_ff <= duty_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         s1_kind_ff  <= front.kind;
         s1_sp_ff    <= s1_sp_in;
         s1_err_ff   <= err;
         s1_acc_ff   <= acc_sat;
         s1_deriv_ff <= deriv;
      end
      if (adv.s2) begin
         s2_kind_ff    <= s1_kind_ff;
         s2_sp_ff      <= s1_sp_ff;
         s2_prod_p_ff  <= prod_p_in;
         s2_prod_d_ff  <= prod_d_in;
         s2_prod_lo_ff <= prod_lo_in;
         s2_prod_hi_ff <= prod_hi_in;
      end
      if (adv.s3) begin
         s3_ff <= s3_in;
      end
   end

   assign lane_out = s3_ff;

endmodule

/* rtl/ddwp_merge.sv */
module ddwp_merge
   import ddwp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ddwp_lane_out_type left,
   input  ddwp_lane_out_type right,
   output logic              take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ddwp_rsp_type      rsp_data
);

   logic         out_valid_ff, out_valid_in;
   ddwp_rsp_type out_ff, out_in;

   always_comb begin
      take = in_valid && (!out_valid_ff || rsp_ready);

      out_in.duty_left    = left.duty;
      out_in.duty_right   = right.duty;
      out_in.dir_left     = left.setpoint[15];
      out_in.dir_right    = !right.setpoint[15];
      out_in.target_left  = left.setpoint;
      out_in.target_right = right.setpoint;

      out_valid_in = take || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* rtl/diff_drive_wheel_pid_top.sv */
// Two-wheel velocity controller. A command transaction moves both slew-limited
// setpoints toward linear -/+ angular * half_track; a measurement transaction
// runs one PID step per wheel on |setpoint| - |measured|. Every transaction
// gives one result. The block takes one transaction per cycle unless the output
// stalls, and passes it through, in order: a front stage forms the shared
// products (angular * half_track and slew_per_ms * elapsed_ms), one stage per
// wheel lane updates the setpoint or integral and previous error, one stage
// forms the gain products, one sums and clamps the duty, and an output register
// holds the result until it is taken. The setpoint and integral update sits in
// a single stage, which is what lets transactions follow each other every cycle
// when nothing stalls. Configuration writes are taken every cycle (csr_ready is
// always high) and must be made while no transaction is in flight; writes to an
// index past the register list are dropped.
`include "diff_drive_wheel_pid_top_assert.svh"

module diff_drive_wheel_pid_top
   import ddwp_pkg::*;
#(
   parameter int ACCUM_BITS = AccumBitsDefault
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ddwp_req_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ddwp_rsp_type            rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [15:0]             csr_data
);

   ddwp_gain_type gain_left_ff, gain_left_in;
   ddwp_gain_type gain_right_ff, gain_right_in;
   logic [15:0]   half_track_ff, half_track_in;
   logic [14:0]   slew_ff, slew_in;

   logic v0_ff, v0_in;
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic load0;
   logic take;
   ddwp_adv_type adv;

   ddwp_front_type    front;
   ddwp_lane_out_type lane_left;
   ddwp_lane_out_type lane_right;

   assign csr_ready = 1'b1;

   always_comb begin
      gain_left_in  = gain_left_ff;
      gain_right_in = gain_right_ff;
      half_track_in = half_track_ff;
      slew_in       = slew_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GAIN_P_LEFT:  gain_left_in.kp  = csr_data;
            REG_GAIN_I_LEFT:  gain_left_in.ki  = csr_data;
            REG_GAIN_D_LEFT:  gain_left_in.kd  = csr_data;
            REG_GAIN_P_RIGHT: gain_right_in.kp = csr_data;
            REG_GAIN_I_RIGHT: gain_right_in.ki = csr_data;
            REG_GAIN_D_RIGHT: gain_right_in.kd = csr_data;
            REG_HALF_TRACK:   half_track_in    = csr_data;
            REG_SLEW_PER_MS:  slew_in          = csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_left_ff  <= '{kp: GAIN_P_RESET, ki: GAIN_I_RESET, kd: GAIN_D_RESET};
         gain_right_ff <= '{kp: GAIN_P_RESET, ki: GAIN_I_RESET, kd: GAIN_D_RESET};
         half_track_ff <= HALF_TRACK_RESET;
         slew_ff       <= SLEW_RESET;
      end else begin
         gain_left_ff  <= gain_left_in;
         gain_right_ff <= gain_right_in;
         half_track_ff <= half_track_in;
         slew_ff       <= slew_in;
      end
   end

   // Each stage loads when it is empty or its transaction moves on.
   always_comb begin
      adv.s3    = v2_ff && (!v3_ff || take);
      adv.s2    = v1_ff && (!v2_ff || adv.s3);
      adv.s1    = v0_ff && (!v1_ff || adv.s2);
      req_ready = !v0_ff || adv.s1;
      load0     = req_valid && req_ready;

      v0_in = load0 || (v0_ff && !adv.s1);
      v1_in = adv.s1 || (v1_ff && !adv.s2);
      v2_in = adv.s2 || (v2_ff && !adv.s3);
      v3_in = adv.s3 || (v3_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   ddwp_front u_front (
      .clock       (clock),
      .load        (load0),
      .req         (req_data),
      .half_track  (half_track_ff),
      .slew_per_ms (slew_ff),
      .stage_out   (front)
   );

   ddwp_lane #(
      .ACCUM_BITS (ACCUM_BITS)
   ) u_lane_left (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .front         (front),
      .meas          (front.meas_left),
      .subtract_term (1'b1),
      .gain          (gain_left_ff),
      .lane_out      (lane_left)
   );

   ddwp_lane #(
      .ACCUM_BITS (ACCUM_BITS)
   ) u_lane_right (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .front         (front),
      .meas          (front.meas_right),
      .subtract_term (1'b0),
      .gain          (gain_right_ff),
      .lane_out      (lane_right)
   );

   ddwp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .left      (lane_left),
      .right     (lane_right),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `DDWP_ASSERT(a_dir_left, rsp_valid |-> (rsp_data.dir_left == rsp_data.target_left[15]), "dir_left bad")
   `DDWP_ASSERT(a_dir_right, rsp_valid |-> (rsp_data.dir_right != rsp_data.target_right[15]), "dir_right bad")
   `DDWP_ASSERT(a_stall_occupied, !req_ready |-> v0_ff, "input stalled with an empty front stage")
   `DDWP_ASSERT_ANY(a_empty_after_reset, (!reset && $past(reset)) |-> !rsp_valid, "result after reset")

endmodule

/* dv/ddwp_wheel_checker.sv */
`timescale 1ns / 100ps

module ddwp_wheel_checker
   import ddwp_pkg::*;
#(
   parameter int ACCUM_BITS = AccumBitsDefault
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  ddwp_req_type            req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ddwp_rsp_type            rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [15:0]             csr_data,
   output int                      fail_count,
   output int                      pending,
   output int                      checked
);

   localparam longint AccMax = (longint'(1) <<< (ACCUM_BITS - 1)) - 1;
   localparam longint AccMin = -AccMax - 1;

   // Index 0 is the left wheel, index 1 the right wheel.
   int                 kp [2];
   int                 ki [2];
   int                 kd [2];
   int                 half_track;
   int                 slew_per_ms;
   logic signed [15:0] setpoint [2];
   longint             accum [2];
   longint             last_err [2];
   logic [15:0]        duty_hold [2];

   ddwp_rsp_type predicted_rsp [$];
   int           errors;
   int           compared;

   assign fail_count = errors;
   assign checked    = compared;

   function automatic logic signed [15:0] clamp_q312(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   function automatic logic signed [15:0] step_toward(input longint sp, input longint goal,
                                                       input longint max_step);
      longint gap;
      gap = goal - sp;
      if (gap > max_step) begin
         gap = max_step;
      end else if (gap < -max_step) begin
         gap = -max_step;
      end
      return 16'(sp + gap);
   endfunction

   task automatic apply_command(input ddwp_req_type item);
      longint term;
      longint max_step;
      term = (longint'(item.cmd_angular) * longint'(half_track)) >>> 16;
      max_step = longint'(slew_per_ms) * longint'(item.elapsed_ms);
      setpoint[0] = step_toward(longint'(setpoint[0]),
                                longint'(clamp_q312(longint'(item.cmd_linear) - term)), max_step);
      setpoint[1] = step_toward(longint'(setpoint[1]),
                                longint'(clamp_q312(longint'(item.cmd_linear) + term)), max_step);
   endtask

   task automatic run_wheel_pid(input int w, input logic signed [15:0] meas);
      longint mag_sp;
      longint mag_meas;
      longint err;
      longint integral;
      longint deriv;
      longint sum;
      longint duty;
      mag_sp = longint'(setpoint[w]);
      if (mag_sp < 0) begin
         mag_sp = -mag_sp;
      end
      mag_meas = longint'(meas);
      if (mag_meas < 0) begin
         mag_meas = -mag_meas;
      end
      err = mag_sp - mag_meas;
      integral = accum[w] + err;
      if (integral > AccMax) begin
         integral = AccMax;
      end else if (integral < AccMin) begin
         integral = AccMin;
      end
      accum[w] = integral;
      deriv = err - last_err[w];
      last_err[w] = err;
      sum = longint'(kp[w]) * err + longint'(ki[w]) * integral + longint'(kd[w]) * deriv;
      // Arithmetic shift on a signed value rounds toward minus infinity.
      duty = sum >>> 12;
      if (duty < 0) begin
         duty = 0;
      end else if (duty > 65535) begin
         duty = 65535;
      end
      duty_hold[w] = 16'(duty);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      ddwp_rsp_type want;
      if (reset) begin
         kp = '{int'(GAIN_P_RESET), int'(GAIN_P_RESET)};
         ki = '{int'(GAIN_I_RESET), int'(GAIN_I_RESET)};
         kd = '{int'(GAIN_D_RESET), int'(GAIN_D_RESET)};
         half_track = int'(HALF_TRACK_RESET);
         slew_per_ms = int'(SLEW_RESET);
         setpoint = '{16'sd0, 16'sd0};
         accum = '{0, 0};
         last_err = '{0, 0};
         duty_hold = '{16'd0, 16'd0};
         predicted_rsp.delete();
         errors = 0;
         compared = 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAIN_P_LEFT:  kp[0] = int'(csr_data);
               REG_GAIN_I_LEFT:  ki[0] = int'(csr_data);
               REG_GAIN_D_LEFT:  kd[0] = int'(csr_data);
               REG_GAIN_P_RIGHT: kp[1] = int'(csr_data);
               REG_GAIN_I_RIGHT: ki[1] = int'(csr_data);
               REG_GAIN_D_RIGHT: kd[1] = int'(csr_data);
               REG_HALF_TRACK:   half_track = int'(csr_data);
               REG_SLEW_PER_MS:  slew_per_ms = int'(csr_data[14:0]);
               default: ;
            endcase
         end
         // Results are retired before new transactions are predicted, so a
         // result in the same cycle as its own request is caught.
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               errors++;
               $display("%0t ns: result with no transaction outstanding, got %p",
                        $time, rsp_data);
            end else begin
               want = predicted_rsp.pop_front();
               compared++;
               check_field("duty_left", want.duty_left, rsp_data.duty_left);
               check_field("duty_right", want.duty_right, rsp_data.duty_right);
               check_field("dir_left", want.dir_left, rsp_data.dir_left);
               check_field("dir_right", want.dir_right, rsp_data.dir_right);
               check_field("target_left", want.target_left, rsp_data.target_left);
               check_field("target_right", want.target_right, rsp_data.target_right);
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.kind == KIND_COMMAND) begin
               apply_command(req_data);
            end else begin
               run_wheel_pid(0, req_data.meas_left);
               run_wheel_pid(1, req_data.meas_right);
            end
            want.duty_left = duty_hold[0];
            want.duty_right = duty_hold[1];
            want.dir_left = setpoint[0] < 0;
            want.dir_right = !(setpoint[1] < 0);
            want.target_left = setpoint[0];
            want.target_right = setpoint[1];
            predicted_rsp.push_back(want);
         end
         pending <= predicted_rsp.size();
      end
   end

endmodule

/* dv/diff_drive_wheel_pid_top_tb.sv */
`timescale 1ns / 100ps

module diff_drive_wheel_pid_top_tb;
   import ddwp_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   ddwp_req_type            req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   ddwp_rsp_type            rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index = REG_GAIN_P_LEFT;
   logic [15:0]             csr_data = '0;

   int fail_count;
   int pending;
   int checked;

   // While steady is set neither side idles.
   logic               steady = 1'b0;
   logic [15:0]        reg_plan [8];
   logic signed [15:0] last_linear = '0;
   int                 n_command = 0;
   int                 n_measure = 0;
   int                 n_settings = 1;

   diff_drive_wheel_pid_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ddwp_wheel_checker #(.ACCUM_BITS(AccumBitsDefault)) i_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(0, 99) >= 38);
   end

   function automatic logic signed [15:0] pick_velocity();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3: return 16'(int'($urandom_range(0, 8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_elapsed();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   // Measurements mostly sit near the last commanded speed so that the
   // duty lands inside its range rather than at a clamp.
   function automatic logic signed [15:0] pick_measure();
      int v;
      if ($urandom_range(0, 3) == 0) begin
         return pick_velocity();
      end
      v = int'(last_linear) + int'($urandom_range(0, 1024)) - 512;
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return 16'(v);
   endfunction

   // Fields of the other kind carry random bits; the block must ignore them.
   function automatic ddwp_req_type make_command(input logic signed [15:0] lin,
                                                 input logic signed [15:0] ang,
                                                 input logic [15:0] elapsed);
      ddwp_req_type item;
      item = {$urandom, $urandom, 17'($urandom)};
      item.kind = KIND_COMMAND;
      item.cmd_linear = lin;
      item.cmd_angular = ang;
      item.elapsed_ms = elapsed;
      last_linear = lin;
      return item;
   endfunction

   function automatic ddwp_req_type make_measure(input logic signed [15:0] left,
                                                 input logic signed [15:0] right);
      ddwp_req_type item;
      item = {$urandom, $urandom, 17'($urandom)};
      item.kind = KIND_MEASURE;
      item.meas_left = left;
      item.meas_right = right;
      return item;
   endfunction

   task automatic send_req(input ddwp_req_type item);
      if (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 38);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      if (item.kind == KIND_COMMAND) begin
         n_command++;
      end else begin
         n_measure++;
      end
   endtask

   // Holds the sender off until every outstanding transaction has returned.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexBits-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_reg_plan();
      logic [CsrIndexBits-1:0] bad_index;
      for (int i = 0; i < 8; i++) begin
         write_csr(CsrIndexBits'(i), reg_plan[i]);
      end
      // An index past the register list must leave every register alone.
      bad_index = CsrIndexBits'(int'(REG_SLEW_PER_MS) + 1 + int'($urandom_range(0, 7)));
      write_csr(bad_index, 16'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
      n_settings++;
   endtask

   task automatic run_random(input int count, input int steady_count);
      steady <= (steady_count > 0);
      for (int i = 0; i < count; i++) begin
         if (i == steady_count) begin
            steady <= 1'b0;
         end
         if ($urandom_range(0, 99) < 25) begin
            send_req(make_command(pick_velocity(), pick_velocity(), pick_elapsed()));
         end else begin
            send_req(make_measure(pick_measure(), pick_measure()));
         end
      end
      steady <= 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("** diff_drive_wheel_pid_top: FAILED **");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      send_req(make_measure(16'sd0, 16'sd0));
      send_req(make_command(16'sh7FFF, 16'sd0, 16'd1));
      send_req(make_measure(16'sd0, 16'sd0));
      send_req(make_command(16'sh7FFF, 16'sh8000, 16'hFFFF));
      send_req(make_measure(16'sh8000, 16'sh7FFF));
      send_req(make_measure(16'sd0, 16'sd0));
      send_req(make_command(16'sh1234, 16'sh0800, 16'd0));
      send_req(make_command(16'sh8000, 16'sh7FFF, 16'hFFFF));
      send_req(make_measure(16'sh7FFF, 16'sh8000));
      send_req(make_measure(16'sh8000, 16'sh8000));
      send_req(make_command(16'sd0, 16'sd0, 16'd3));
      send_req(make_measure(16'sh7FFF, 16'sh7FFF));
      send_req(make_command(16'sh1000, -16'sh1000, 16'd10));
      send_req(make_measure(16'sh1000, -16'sh1000));
      send_req(make_command(-16'sh0800, 16'sh0400, 16'd2));
      send_req(make_measure(16'sh0700, -16'sh0900));
      send_req(make_measure(-16'sh0700, 16'sh0900));
      send_req(make_command(16'sh7FFF, 16'sh7FFF, 16'hFFFF));
      send_req(make_command(16'sh8000, 16'sh8000, 16'hFFFF));
      send_req(make_measure(16'sd0, 16'sd1));
      wait_idle();

      // Every register at its maximum; the top data bit of the slew is dropped.
      for (int i = 0; i < 8; i++) begin
         reg_plan[i] = 16'hFFFF;
      end
      apply_reg_plan();
      run_random(50, 0);
      wait_idle();
      run_random(50, 0);
      wait_idle();

      // Zero gains, zero track and zero slew: the setpoints never move.
      for (int i = 0; i < 8; i++) begin
         reg_plan[i] = 16'h0000;
      end
      apply_reg_plan();
      send_req(make_command(16'sh7FFF, 16'sh7FFF, 16'hFFFF));
      run_random(40, 0);
      wait_idle();

      for (int s = 0; s < 3; s++) begin
         for (int i = 0; i < 8; i++) begin
            reg_plan[i] = 16'($urandom) >> $urandom_range(0, 10);
         end
         reg_plan[REG_HALF_TRACK] = 16'($urandom);
         reg_plan[REG_SLEW_PER_MS] = 16'($urandom);
         apply_reg_plan();
         run_random(100, (s == 0) ? 80 : 0);
         wait_idle();
      end

      reg_plan[REG_GAIN_P_LEFT] = GAIN_P_RESET;
      reg_plan[REG_GAIN_I_LEFT] = GAIN_I_RESET;
      reg_plan[REG_GAIN_D_LEFT] = GAIN_D_RESET;
      reg_plan[REG_GAIN_P_RIGHT] = GAIN_P_RESET;
      reg_plan[REG_GAIN_I_RIGHT] = GAIN_I_RESET;
      reg_plan[REG_GAIN_D_RIGHT] = GAIN_D_RESET;
      reg_plan[REG_HALF_TRACK] = HALF_TRACK_RESET;
      reg_plan[REG_SLEW_PER_MS] = {1'b0, SLEW_RESET};
      apply_reg_plan();
      run_random(60, 0);
      wait_idle();

      $display("Covered %0d velocity commands and %0d measurements under %0d register settings,",
               n_command, n_measure, n_settings);
      $display("with extreme, zero and random gains; %0d results compared.", checked);
      if (fail_count == 0 && pending == 0) begin
         $display("** diff_drive_wheel_pid_top: PASSED **");
      end else begin
         $display("** diff_drive_wheel_pid_top: FAILED **");
      end
      $finish;
   end

endmodule
